// ----- hw/rtl/djs_pkg.sv -----
package djs_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SPEED_W  = 15;
    localparam int unsigned TARGET_W = 14;
    localparam int unsigned RATE_W   = 8;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned DIR_W    = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned STEP_W   = RATE_W + TIME_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_SPEED     = 3'd0,
        REG_RAMP_RATE        = 3'd1,
        REG_DEBOUNCE_TIME    = 3'd2,
        REG_CONTROL_PERIOD   = 3'd3,
        REG_HEARTBEAT_PERIOD = 3'd4
    } cfg_index_t;

    localparam logic [DIR_W-1:0] DIR_STOP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REVERSE = 2'd2;

    localparam logic [TARGET_W-1:0] TARGET_SPEED_RST     = 14'd4000;
    localparam logic [RATE_W-1:0]   RAMP_RATE_RST        = 8'd2;
    localparam logic [PERIOD_W-1:0] DEBOUNCE_TIME_RST    = 16'd25;
    localparam logic [PERIOD_W-1:0] CONTROL_PERIOD_RST   = 16'd5;
    localparam logic [PERIOD_W-1:0] HEARTBEAT_PERIOD_RST = 16'd5;

    typedef struct packed {
        logic [TARGET_W-1:0] target_speed;
        logic [RATE_W-1:0]   ramp_rate;
        logic [PERIOD_W-1:0] debounce_time;
        logic [PERIOD_W-1:0] control_period;
        logic [PERIOD_W-1:0] heartbeat_period;
    } cfg_t;

    typedef struct packed {
        logic                      setpoint_update;
        logic signed [SPEED_W-1:0] setpoint_rpm;
        logic                      heartbeat_due;
    } ramp_result_t;

endpackage

// ----- hw/rtl/djs_in_if.sv -----
interface djs_in_if
    import djs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] now_ms;
    logic              forward_raw;
    logic              reverse_raw;

    modport source (output valid, now_ms, forward_raw, reverse_raw, input ready);
    modport sink   (input valid, now_ms, forward_raw, reverse_raw, output ready);
endinterface

// ----- hw/rtl/djs_out_if.sv -----
interface djs_out_if
    import djs_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      setpoint_update;
    logic signed [SPEED_W-1:0] setpoint_rpm;
    logic                      heartbeat_due;
    logic [DIR_W-1:0]          direction;

    modport source (output valid, setpoint_update, setpoint_rpm, heartbeat_due, direction,
                    input ready);
    modport sink   (input valid, setpoint_update, setpoint_rpm, heartbeat_due, direction,
                    output ready);
endinterface

// ----- hw/rtl/djs_cfg_if.sv -----
interface djs_cfg_if
    import djs_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/djs_debounce.sv -----
module djs_debounce
    import djs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic [TIME_W-1:0]   now,
    input  logic                raw,
    input  logic [PERIOD_W-1:0] debounce_time,
    output logic                stable
);

    logic              level_reg, level_next;
    logic              stable_reg, stable_next;
    logic [TIME_W-1:0] since_reg, since_next;
    logic [TIME_W-1:0] held;

    always_comb
    begin
        level_next  = raw;
        since_next  = (raw != level_reg) ? now : since_reg;
        held        = now - since_next;
        stable_next = (held >= {{(TIME_W-PERIOD_W){1'b0}}, debounce_time}) ? raw : stable_reg;
    end

    assign stable = stable_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= 1'b0;
            stable_reg <= 1'b0;
            since_reg  <= '0;
        end
        else if (en)
        begin
            level_reg  <= level_next;
            stable_reg <= stable_next;
            since_reg  <= since_next;
        end
    end

endmodule

// ----- hw/rtl/djs_ramp.sv -----
module djs_ramp
    import djs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [TIME_W-1:0]         now,
    input  logic signed [SPEED_W-1:0] target,
    input  cfg_t                      cfg,
    output ramp_result_t              result
);

    logic [TIME_W-1:0]         ctrl_time_reg, ctrl_time_next;
    logic [TIME_W-1:0]         beat_time_reg, beat_time_next;
    logic signed [SPEED_W-1:0] speed_reg, speed_next;

    logic [TIME_W-1:0]         ctrl_elapsed;
    logic [TIME_W-1:0]         beat_elapsed;
    logic                      ctrl_due;
    logic                      beat_due;
    logic [STEP_W-1:0]         step;
    logic signed [SPEED_W:0]   diff;
    logic [SPEED_W:0]          gap;
    logic                      step_reaches;

    always_comb
    begin
        ctrl_elapsed = now - ctrl_time_reg;
        beat_elapsed = now - beat_time_reg;
        ctrl_due = ctrl_elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, cfg.control_period};
        beat_due = beat_elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, cfg.heartbeat_period};

        step = {{TIME_W{1'b0}}, cfg.ramp_rate} * {{RATE_W{1'b0}}, ctrl_elapsed};
        diff = {target[SPEED_W-1], target} - {speed_reg[SPEED_W-1], speed_reg};
        gap  = diff[SPEED_W] ? (~diff + 1'b1) : diff;
        step_reaches = step >= {{(STEP_W-SPEED_W-1){1'b0}}, gap};

        speed_next = speed_reg;
        if (ctrl_due && (diff != '0))
        begin
            if (step_reaches)
                speed_next = target;
            else if (diff[SPEED_W])
                speed_next = speed_reg - $signed(step[SPEED_W-1:0]);
            else
                speed_next = speed_reg + $signed(step[SPEED_W-1:0]);
        end

        ctrl_time_next = ctrl_due ? now : ctrl_time_reg;
        beat_time_next = beat_due ? now : beat_time_reg;

        result.setpoint_update = ctrl_due;
        result.setpoint_rpm    = speed_next;
        result.heartbeat_due   = beat_due;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_time_reg <= '0;
            beat_time_reg <= '0;
            speed_reg     <= '0;
        end
        else if (en)
        begin
            ctrl_time_reg <= ctrl_time_next;
            beat_time_reg <= beat_time_next;
            speed_reg     <= speed_next;
        end
    end

endmodule

// ----- hw/rtl/debounced_jog_speed_ramp.sv -----
// Debounced jog buttons driving a slew-limited speed setpoint.
//
// sample: one beat per timestamped button reading (now_ms, forward_raw,
//   reverse_raw). result: exactly one beat per sample beat, in order,
//   carrying setpoint_update, setpoint_rpm, heartbeat_due and direction.
// cfg: register writes (index 0..4), always ready; write only while idle.
//
// A sample beat passes through the input register, then the result register,
// before its result beat is offered on result. Throughput is one beat per
// cycle while the result side does not stall: the debounce, control and
// heartbeat state is updated as a beat moves from the input register into
// the result register, so consecutive beats see each other's state updates.
//
// When the result side stalls, the result register holds its beat and the
// input register takes one more; sample.ready then drops until result moves.
// Reset clears all timestamps, debounce state and the setpoint to zero and
// restores the register defaults (4000 rpm, 2 rpm/ms, 25 ms, 5 ms, 5 ms).
module debounced_jog_speed_ramp
    import djs_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    djs_in_if.sink    sample,
    djs_out_if.source result,
    djs_cfg_if.sink   cfg
);

    cfg_t cfg_reg;

    logic              in_valid_reg;
    logic [TIME_W-1:0] now_reg;
    logic              fwd_raw_reg;
    logic              rev_raw_reg;

    logic                      out_valid_reg;
    logic                      update_reg;
    logic signed [SPEED_W-1:0] rpm_reg;
    logic                      beat_reg;
    logic [DIR_W-1:0]          dir_reg;

    logic                      advance;
    logic                      fwd;
    logic                      rev;
    logic [DIR_W-1:0]          dir_next;
    logic signed [SPEED_W-1:0] target;
    ramp_result_t              ramp_res;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_speed     <= TARGET_SPEED_RST;
            cfg_reg.ramp_rate        <= RAMP_RATE_RST;
            cfg_reg.debounce_time    <= DEBOUNCE_TIME_RST;
            cfg_reg.control_period   <= CONTROL_PERIOD_RST;
            cfg_reg.heartbeat_period <= HEARTBEAT_PERIOD_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TARGET_SPEED:     cfg_reg.target_speed     <= cfg.data[TARGET_W-1:0];
                REG_RAMP_RATE:        cfg_reg.ramp_rate        <= cfg.data[RATE_W-1:0];
                REG_DEBOUNCE_TIME:    cfg_reg.debounce_time    <= cfg.data;
                REG_CONTROL_PERIOD:   cfg_reg.control_period   <= cfg.data;
                REG_HEARTBEAT_PERIOD: cfg_reg.heartbeat_period <= cfg.data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (sample.ready)
            in_valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            now_reg     <= sample.now_ms;
            fwd_raw_reg <= sample.forward_raw;
            rev_raw_reg <= sample.reverse_raw;
        end
    end

    djs_debounce u_fwd_debounce (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (advance),
        .now           (now_reg),
        .raw           (fwd_raw_reg),
        .debounce_time (cfg_reg.debounce_time),
        .stable        (fwd)
    );

    djs_debounce u_rev_debounce (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (advance),
        .now           (now_reg),
        .raw           (rev_raw_reg),
        .debounce_time (cfg_reg.debounce_time),
        .stable        (rev)
    );

    always_comb
    begin
        dir_next = DIR_STOP;
        target   = '0;
        if (fwd && !rev)
        begin
            dir_next = DIR_FORWARD;
            target   = $signed({1'b0, cfg_reg.target_speed});
        end
        else if (rev && !fwd)
        begin
            dir_next = DIR_REVERSE;
            target   = -$signed({1'b0, cfg_reg.target_speed});
        end
    end

    djs_ramp u_ramp (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .now    (now_reg),
        .target (target),
        .cfg    (cfg_reg),
        .result (ramp_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            update_reg <= ramp_res.setpoint_update;
            rpm_reg    <= ramp_res.setpoint_rpm;
            beat_reg   <= ramp_res.heartbeat_due;
            dir_reg    <= dir_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.setpoint_update = update_reg;
    assign result.setpoint_rpm    = rpm_reg;
    assign result.heartbeat_due   = beat_reg;
    assign result.direction       = dir_reg;

endmodule

// ----- tb/testbench.sv -----
module testbench;
    import djs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic                      update;
        logic signed [SPEED_W-1:0] rpm;
        logic                      beat;
        logic [DIR_W-1:0]          dir;
    } jog_beat_t;

    logic clk;
    logic rst_n;

    djs_in_if  sample_if ();
    djs_out_if result_if ();
    djs_cfg_if cfg_if ();

    debounced_jog_speed_ramp DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    // predictor copy of the registers and state
    logic [TARGET_W-1:0] cfg_target    = TARGET_SPEED_RST;
    logic [RATE_W-1:0]   cfg_rate      = RAMP_RATE_RST;
    logic [PERIOD_W-1:0] cfg_debounce  = DEBOUNCE_TIME_RST;
    logic [PERIOD_W-1:0] cfg_ctrl_per  = CONTROL_PERIOD_RST;
    logic [PERIOD_W-1:0] cfg_beat_per  = HEARTBEAT_PERIOD_RST;

    logic              btn_level [2] = '{1'b0, 1'b0};
    logic              btn_stable[2] = '{1'b0, 1'b0};
    logic [TIME_W-1:0] btn_since [2] = '{32'd0, 32'd0};
    logic [TIME_W-1:0] ctrl_stamp    = '0;
    logic [TIME_W-1:0] beat_stamp    = '0;
    int                speed_rpm     = 0;

    jog_beat_t         expected_beats[$];
    int                mismatch_count = 0;
    int                cycle_count = 0;
    logic [TIME_W-1:0] clock_ms = '0;
    logic              sender_gaps = 1'b1;
    logic              receiver_gaps = 1'b1;
    logic              hold_flag = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic debounce_button(input int b, input logic raw,
                                             input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] held_for;
        if (raw != btn_level[b])
        begin
            btn_level[b] = raw;
            btn_since[b] = now;
        end
        held_for = now - btn_since[b];
        if (held_for >= {16'd0, cfg_debounce})
            btn_stable[b] = raw;
        return btn_stable[b];
    endfunction

    function automatic jog_beat_t predict_jog_result(input logic [TIME_W-1:0] now,
                                                     input logic fraw, input logic rraw);
        jog_beat_t         res;
        logic              fwd;
        logic              rev;
        int                goal;
        logic [TIME_W-1:0] elapsed;
        longint            step;
        res = '0;
        goal = 0;
        fwd = debounce_button(0, fraw, now);
        rev = debounce_button(1, rraw, now);
        res.dir = DIR_STOP;
        if (fwd && !rev)
        begin
            res.dir = DIR_FORWARD;
            goal = int'(cfg_target);
        end
        else if (rev && !fwd)
        begin
            res.dir = DIR_REVERSE;
            goal = -int'(cfg_target);
        end
        elapsed = now - beat_stamp;
        if (elapsed >= {16'd0, cfg_beat_per})
        begin
            res.beat = 1'b1;
            beat_stamp = now;
        end
        elapsed = now - ctrl_stamp;
        if (elapsed >= {16'd0, cfg_ctrl_per})
        begin
            step = longint'(cfg_rate) * longint'(elapsed);
            if (goal > speed_rpm)
                speed_rpm = (step >= longint'(goal - speed_rpm)) ? goal : speed_rpm + int'(step);
            else if (goal < speed_rpm)
                speed_rpm = (step >= longint'(speed_rpm - goal)) ? goal : speed_rpm - int'(step);
            res.update = 1'b1;
            ctrl_stamp = now;
        end
        res.rpm = speed_rpm[SPEED_W-1:0];
        return res;
    endfunction

    task automatic send_sample(input logic [TIME_W-1:0] now, input logic fraw,
                               input logic rraw);
        if (sender_gaps && $urandom_range(99) < 31)
        begin
            sample_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 31);
        end
        sample_if.valid       <= 1'b1;
        sample_if.now_ms      <= now;
        sample_if.forward_raw <= fraw;
        sample_if.reverse_raw <= rraw;
        do @(posedge clk); while (!sample_if.ready);
        expected_beats.push_back(predict_jog_result(now, fraw, rraw));
    endtask

    task automatic settle_block();
        sample_if.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_TARGET_SPEED:     cfg_target   = value[TARGET_W-1:0];
            REG_RAMP_RATE:        cfg_rate     = value[RATE_W-1:0];
            REG_DEBOUNCE_TIME:    cfg_debounce = value;
            REG_CONTROL_PERIOD:   cfg_ctrl_per = value;
            REG_HEARTBEAT_PERIOD: cfg_beat_per = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input logic [CFG_DATA_W-1:0] top,
                                                            input logic [CFG_DATA_W-1:0] typical);
        int r;
        r = int'($urandom_range(9));
        if (r == 0)
            return '0;
        if (r == 1)
            return top;
        return typical;
    endfunction

    task automatic configure_random();
        write_reg(REG_TARGET_SPEED, pick_reg_value(16'hFFFF, 16'($urandom)));
        write_reg(REG_RAMP_RATE, pick_reg_value(16'h00FF, 16'($urandom)));
        write_reg(REG_DEBOUNCE_TIME, pick_reg_value(16'hFFFF, 16'($urandom_range(0, 30))));
        write_reg(REG_CONTROL_PERIOD, pick_reg_value(16'hFFFF, 16'($urandom_range(1, 12))));
        write_reg(REG_HEARTBEAT_PERIOD, pick_reg_value(16'hFFFF, 16'($urandom_range(1, 12))));
    endtask

    // held button patterns with occasional bounce and time jumps
    task automatic send_jog_burst(input int count);
        logic [1:0] pattern;
        logic [1:0] buttons;
        logic [1:0] flip;
        int         hold;
        int         pick;
        pattern = 2'b00;
        hold = 0;
        for (int i = 0; i < count; i++)
        begin
            if (hold == 0)
            begin
                pattern = 2'($urandom_range(3));
                hold = int'($urandom_range(1, 12));
            end
            hold--;
            buttons = pattern;
            if ($urandom_range(99) < 10)
            begin
                flip = 2'($urandom_range(1, 2));
                buttons = buttons ^ flip;
            end
            pick = int'($urandom_range(99));
            if (pick < 85)
                clock_ms = clock_ms + $urandom_range(0, 6);
            else if (pick < 95)
                clock_ms = clock_ms + $urandom_range(7, 300);
            else
                clock_ms = $urandom;
            send_sample(clock_ms, buttons[1], buttons[0]);
        end
    endtask

    task automatic test_reset_defaults();
        send_sample(32'd0,   1'b0, 1'b0);
        send_sample(32'd3,   1'b1, 1'b0);
        send_sample(32'd10,  1'b1, 1'b0);
        send_sample(32'd20,  1'b1, 1'b0);
        send_sample(32'd28,  1'b1, 1'b0);
        send_sample(32'd30,  1'b1, 1'b0);
        send_sample(32'd40,  1'b1, 1'b1);
        send_sample(32'd70,  1'b1, 1'b1);
        send_sample(32'd80,  1'b0, 1'b1);
        send_sample(32'd110, 1'b0, 1'b1);
        send_sample(32'd111, 1'b0, 1'b0);
        settle_block();
    endtask

    task automatic test_register_extremes();
        // upper bits of target and rate are masked off
        write_reg(REG_TARGET_SPEED, 16'hFFFF);
        write_reg(REG_RAMP_RATE, 16'h01FF);
        write_reg(REG_DEBOUNCE_TIME, 16'h0000);
        write_reg(REG_CONTROL_PERIOD, 16'h0000);
        write_reg(REG_HEARTBEAT_PERIOD, 16'h0000);
        send_sample(32'd200,        1'b1, 1'b0);
        send_sample(32'd200,        1'b1, 1'b0);
        send_sample(32'd1200,       1'b1, 1'b0);
        send_sample(32'd1200,       1'b0, 1'b1);
        send_sample(32'd1201,       1'b0, 1'b1);
        send_sample(32'hFFFF_FFF0,  1'b0, 1'b1);
        send_sample(32'd5,          1'b1, 1'b1);
        send_sample(32'd64,         1'b1, 1'b1);
        settle_block();
        write_reg(REG_RAMP_RATE, 16'h0000);
        write_reg(REG_DEBOUNCE_TIME, 16'hFFFF);
        write_reg(REG_CONTROL_PERIOD, 16'hFFFF);
        write_reg(REG_HEARTBEAT_PERIOD, 16'hFFFF);
        send_sample(32'd100,        1'b1, 1'b0);
        send_sample(32'd65636,      1'b1, 1'b0);
        send_sample(32'hFFFF_0000,  1'b0, 1'b1);
        send_sample(32'hFFFF_FFFF,  1'b0, 1'b1);
        settle_block();
    endtask

    task automatic test_random_jog();
        clock_ms = 32'hFFFF_FF00;
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_gaps   = (phase != 2);
            receiver_gaps = (phase != 2);
            configure_random();
            send_jog_burst(50);
            settle_block();
            send_jog_burst(50);
            settle_block();
        end
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    task automatic test_backpressure();
        configure_random();
        sender_gaps = 1'b0;
        hold_flag <= ~hold_flag;
        send_jog_burst(50);
        settle_block();
        sender_gaps = 1'b1;
    endtask

    initial
    begin : result_ready_driver
        logic hold_seen;
        int   hold_left;
        hold_seen = 1'b0;
        hold_left = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_flag != hold_seen)
            begin
                hold_seen = hold_flag;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= !(receiver_gaps && $urandom_range(99) < 31);
        end
    end

    always @(posedge clk)
    begin : check_results
        jog_beat_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_beats.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result beat: rpm %0d dir %0d",
                             result_if.setpoint_rpm, result_if.direction);
                mismatch_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (result_if.setpoint_update !== want.update ||
                    result_if.setpoint_rpm    !== want.rpm    ||
                    result_if.heartbeat_due   !== want.beat   ||
                    result_if.direction       !== want.dir)
                begin
                    if (mismatch_count < 10)
                        $display({"result beat: exp upd %0b rpm %0d hb %0b dir %0d, ",
                                  "got upd %0b rpm %0d hb %0b dir %0d"},
                                 want.update, $signed(want.rpm), want.beat, want.dir,
                                 result_if.setpoint_update, result_if.setpoint_rpm,
                                 result_if.heartbeat_due, result_if.direction);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        sample_if.valid       = 1'b0;
        sample_if.now_ms      = '0;
        sample_if.forward_raw = 1'b0;
        sample_if.reverse_raw = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_random_jog();
        test_backpressure();
        settle_block();
        mismatch_count += expected_beats.size();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/djs_pkg.sv
hw/rtl/djs_in_if.sv
hw/rtl/djs_out_if.sv
hw/rtl/djs_cfg_if.sv
hw/rtl/djs_debounce.sv
hw/rtl/djs_ramp.sv
hw/rtl/debounced_jog_speed_ramp.sv
tb/testbench.sv
